// ===== rtl/rwla_pkg.sv =====
// types and constants shared by the reader/writer lock arbiter
// no dependencies
`default_nettype none

package rwla_pkg;

    localparam logic [3:0] DELAY_MAX   = 4'd15;
    localparam logic [3:0] LIMIT_RESET = 4'd3;

    localparam logic [1:0] MODE_RD_REQ = 2'd0;
    localparam logic [1:0] MODE_RD_REL = 2'd1;
    localparam logic [1:0] MODE_WR_REQ = 2'd2;
    localparam logic [1:0] MODE_WR_REL = 2'd3;

    typedef struct packed {
        logic [2:0] requester;
        logic [1:0] mode;
    } in_item_t;

    typedef struct packed {
        logic [7:0] grant_mask;
        logic       grant_is_write;
        logic       priority_flag;
        logic [3:0] reader_count;
        logic [3:0] readers_waiting;
        logic [3:0] writers_waiting;
        logic       bad_event;
    } out_item_t;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_WSCAN = 2'd1,
        ACT_RSCAN = 2'd2
    } act_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic wstep;
        logic rstep;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        act_t act;
        logic w_found;
        logic r_last;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/rwla_ctrl.sv =====
// sequencing state machine of the lock arbiter: handshakes and scan control
// depends on rwla_pkg
`default_nettype none

module rwla_ctrl
    import rwla_pkg::*;
(
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  wire        m_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_EXEC  = 5'b00010,
        ST_WSCAN = 5'b00100,
        ST_RSCAN = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                case (status.act)
                    ACT_WSCAN: state_next = ST_WSCAN;
                    ACT_RSCAN: state_next = ST_RSCAN;
                    default:   state_next = ST_DONE;
                endcase
            end
            ST_WSCAN: begin
                cmd.wstep = 1'b1;
                if (status.w_found) begin
                    state_next = ST_DONE;
                end
            end
            ST_RSCAN: begin
                cmd.rstep = 1'b1;
                if (status.r_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rwla_datapath.sv =====
// lock state, event evaluation, index scan and result register of the arbiter
// depends on rwla_pkg
`default_nettype none

module rwla_datapath
    import rwla_pkg::*;
#(
    parameter int REQUESTERS = 8
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  in_item_t   s_item,
    input  wire        cfg_we,
    input  wire  [3:0] cfg_wdata,
    input  ctrl_cmd_t  cmd,
    output dp_status_t status,
    output out_item_t  m_item
);

    localparam int IW = (REQUESTERS > 2) ? $clog2(REQUESTERS) : 1;
    localparam int CW = $clog2(REQUESTERS + 1);
    localparam int GW = (REQUESTERS > 8) ? REQUESTERS : 8;
    localparam int EW = (CW > 4) ? CW : 4;
    localparam logic [REQUESTERS-1:0] ONE = REQUESTERS'(1);
    localparam logic [IW-1:0] LAST_IDX = IW'(REQUESTERS - 1);

    logic [2:0]            req_reg, req_next;
    logic [1:0]            mode_reg, mode_next;
    logic [REQUESTERS-1:0] rp_reg, rp_next;
    logic [REQUESTERS-1:0] wp_reg, wp_next;
    logic [REQUESTERS-1:0] rh_reg, rh_next;
    logic [CW-1:0]         rp_cnt_reg, rp_cnt_next;
    logic [CW-1:0]         wp_cnt_reg, wp_cnt_next;
    logic [CW-1:0]         rh_cnt_reg, rh_cnt_next;
    logic                  busy_reg, busy_next;
    logic [IW-1:0]         owner_reg, owner_next;
    logic [3:0]            dc_reg, dc_next;
    logic                  favor_reg, favor_next;
    logic [3:0]            limit_reg;
    logic [REQUESTERS-1:0] grant_reg, grant_next;
    logic                  is_write_reg, is_write_next;
    logic                  bad_reg, bad_next;
    logic [IW-1:0]         idx_reg, idx_next;
    out_item_t             out_reg;

    logic                  req_ok;
    logic [IW-1:0]         req_idx;
    logic [REQUESTERS-1:0] req_bit;
    logic [REQUESTERS-1:0] scan_bit;
    logic                  owns_write;
    logic                  involved;
    logic                  wp_any;
    logic                  rp_any;
    logic                  blocked;
    logic                  admit_delays;
    logic [3:0]            dc_inc;
    logic [GW-1:0]         grant_ext;
    logic [EW-1:0]         rh_ext, rp_ext, wp_ext;

    assign req_ok       = ({4'b0, req_reg} < 7'(REQUESTERS));
    assign req_idx      = IW'(req_reg);
    assign req_bit      = ONE << req_idx;
    assign scan_bit     = ONE << idx_reg;
    assign owns_write   = busy_reg && (owner_reg == req_idx);
    assign involved     = (((rp_reg | wp_reg | rh_reg) & req_bit) != '0) || owns_write;
    assign wp_any       = (wp_cnt_reg != '0);
    assign rp_any       = (rp_cnt_reg != '0);
    assign blocked      = busy_reg || (favor_reg && wp_any);
    assign admit_delays = wp_any && !favor_reg;
    assign dc_inc       = (dc_reg < DELAY_MAX) ? dc_reg + 4'd1 : dc_reg;

    assign grant_ext = GW'(grant_reg);
    assign rh_ext    = EW'(rh_cnt_reg);
    assign rp_ext    = EW'(rp_cnt_reg);
    assign wp_ext    = EW'(wp_cnt_reg);

    always_comb begin
        req_next      = req_reg;
        mode_next     = mode_reg;
        rp_next       = rp_reg;
        wp_next       = wp_reg;
        rh_next       = rh_reg;
        rp_cnt_next   = rp_cnt_reg;
        wp_cnt_next   = wp_cnt_reg;
        rh_cnt_next   = rh_cnt_reg;
        busy_next     = busy_reg;
        owner_next    = owner_reg;
        dc_next       = dc_reg;
        favor_next    = favor_reg;
        grant_next    = grant_reg;
        is_write_next = is_write_reg;
        bad_next      = bad_reg;
        idx_next      = idx_reg;
        status        = '{act: ACT_NONE, w_found: wp_reg[idx_reg], r_last: idx_reg == LAST_IDX};

        if (cmd.capture) begin
            req_next  = s_item.requester;
            mode_next = s_item.mode;
        end

        if (cmd.exec) begin
            grant_next    = '0;
            is_write_next = 1'b0;
            bad_next      = 1'b0;
            idx_next      = '0;
            case (mode_reg)
                MODE_RD_REQ: begin
                    if (!req_ok || involved) begin
                        bad_next = 1'b1;
                    end else if (blocked) begin
                        rp_next     = rp_reg | req_bit;
                        rp_cnt_next = rp_cnt_reg + CW'(1);
                    end else begin
                        if (admit_delays) begin
                            dc_next = dc_inc;
                            if (dc_inc >= limit_reg) begin
                                favor_next = 1'b1;
                            end
                        end
                        rh_next     = rh_reg | req_bit;
                        rh_cnt_next = rh_cnt_reg + CW'(1);
                        grant_next  = req_bit;
                    end
                end
                MODE_RD_REL: begin
                    if (!req_ok || ((rh_reg & req_bit) == '0)) begin
                        bad_next = 1'b1;
                    end else begin
                        rh_next     = rh_reg & ~req_bit;
                        rh_cnt_next = rh_cnt_reg - CW'(1);
                        if ((rh_cnt_reg == CW'(1)) && wp_any && !busy_reg) begin
                            status.act = ACT_WSCAN;
                        end
                    end
                end
                MODE_WR_REQ: begin
                    if (!req_ok || involved) begin
                        bad_next = 1'b1;
                    end else if (!busy_reg && (rh_cnt_reg == '0)) begin
                        busy_next     = 1'b1;
                        owner_next    = req_idx;
                        dc_next       = '0;
                        favor_next    = 1'b0;
                        grant_next    = req_bit;
                        is_write_next = 1'b1;
                    end else begin
                        wp_next     = wp_reg | req_bit;
                        wp_cnt_next = wp_cnt_reg + CW'(1);
                    end
                end
                MODE_WR_REL: begin
                    if (!req_ok || !owns_write) begin
                        bad_next = 1'b1;
                    end else begin
                        busy_next = 1'b0;
                        if (wp_any && favor_reg) begin
                            status.act = ACT_WSCAN;
                        end else if (rp_any) begin
                            status.act = ACT_RSCAN;
                        end else if (wp_any) begin
                            status.act = ACT_WSCAN;
                        end
                    end
                end
                default: bad_next = 1'b1;
            endcase
        end

        if (cmd.wstep) begin
            idx_next = idx_reg + IW'(1);
            if (wp_reg[idx_reg]) begin
                wp_next       = wp_reg & ~scan_bit;
                wp_cnt_next   = wp_cnt_reg - CW'(1);
                busy_next     = 1'b1;
                owner_next    = idx_reg;
                dc_next       = '0;
                favor_next    = 1'b0;
                grant_next    = scan_bit;
                is_write_next = 1'b1;
            end
        end

        if (cmd.rstep) begin
            idx_next = idx_reg + IW'(1);
            if (rp_reg[idx_reg] && !blocked) begin
                rp_next     = rp_reg & ~scan_bit;
                rp_cnt_next = rp_cnt_reg - CW'(1);
                if (admit_delays) begin
                    dc_next = dc_inc;
                    if (dc_inc >= limit_reg) begin
                        favor_next = 1'b1;
                    end
                end
                rh_next     = rh_reg | scan_bit;
                rh_cnt_next = rh_cnt_reg + CW'(1);
                grant_next  = grant_reg | scan_bit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rp_reg     <= '0;
            wp_reg     <= '0;
            rh_reg     <= '0;
            rp_cnt_reg <= '0;
            wp_cnt_reg <= '0;
            rh_cnt_reg <= '0;
            busy_reg   <= 1'b0;
            owner_reg  <= '0;
            dc_reg     <= '0;
            favor_reg  <= 1'b0;
            limit_reg  <= LIMIT_RESET;
        end else begin
            rp_reg     <= rp_next;
            wp_reg     <= wp_next;
            rh_reg     <= rh_next;
            rp_cnt_reg <= rp_cnt_next;
            wp_cnt_reg <= wp_cnt_next;
            rh_cnt_reg <= rh_cnt_next;
            busy_reg   <= busy_next;
            owner_reg  <= owner_next;
            dc_reg     <= dc_next;
            favor_reg  <= favor_next;
            if (cfg_we) begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        mode_reg     <= mode_next;
        grant_reg    <= grant_next;
        is_write_reg <= is_write_next;
        bad_reg      <= bad_next;
        idx_reg      <= idx_next;
        if (cmd.load_out) begin
            out_reg.grant_mask      <= grant_ext[7:0];
            out_reg.grant_is_write  <= is_write_reg;
            out_reg.priority_flag   <= favor_reg;
            out_reg.reader_count    <= rh_ext[3:0];
            out_reg.readers_waiting <= rp_ext[3:0];
            out_reg.writers_waiting <= wp_ext[3:0];
            out_reg.bad_event       <= bad_reg;
        end
    end

    assign m_item = out_reg;

endmodule

`default_nettype wire

// ===== rtl/reader_writer_lock_arbiter.sv =====
// reader/writer lock arbiter with a writer starvation limit, top level
// depends on rwla_pkg, rwla_ctrl and rwla_datapath
//
// s_item carries one lock event (requester, mode) on a valid/ready channel.
// m_item returns one result per event: grants made, writer priority, the
// holding and waiting counts and a flag for an event that was ignored.
// cfg_we/cfg_wdata write the delay limit; write it only while idle.
// an event that needs no scan passes ST_EXEC and ST_DONE to the result
// register, and s_ready returns once the result is loaded, so a new event
// is not taken before the last is through. a grant to a waiting writer
// walks the pending writers one index a cycle; a write release that wakes
// readers walks all REQUESTERS indexes in order, one per cycle.
// s_ready is high only between events; the next event can be accepted while
// the previous result still waits in the output register.
// if the receiver stalls, a finished event holds in the controller until
// the output register frees up.
// reset empties all lock state, clears writer priority and sets the delay
// limit to 3; no result is pending after reset.
`default_nettype none

module reader_writer_lock_arbiter
    import rwla_pkg::*;
#(
    parameter int REQUESTERS = 8
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_valid,
    output logic       s_ready,
    input  in_item_t   s_item,
    output logic       m_valid,
    input  wire        m_ready,
    output out_item_t  m_item,
    input  wire        cfg_we,
    input  wire  [3:0] cfg_wdata
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    rwla_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rwla_datapath #(
        .REQUESTERS (REQUESTERS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_item    (s_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .m_item    (m_item)
    );

endmodule

`default_nettype wire

// ===== rtl/rwla_checker.sv =====
// port-level checks of the lock arbiter and the bind that attaches them
// depends on rwla_pkg and reader_writer_lock_arbiter
`default_nettype none

module rwla_checker
    import rwla_pkg::*;
(
    input wire       aclk,
    input wire       aresetn,
    input wire       s_valid,
    input wire       s_ready,
    input wire       m_valid,
    input wire       m_ready,
    input out_item_t m_item
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item accepted while another is in work");

    a_bad_no_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.bad_event |-> m_item.grant_mask == 8'd0 && !m_item.grant_is_write)
        else $error("ignored item carries a grant");

    a_writer_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.grant_is_write |-> $onehot0(m_item.grant_mask) && !m_item.priority_flag)
        else $error("writer grant not exclusive or priority left on");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind reader_writer_lock_arbiter rwla_checker u_rwla_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

`default_nettype wire

// ===== tb/tb_reader_writer_lock_arbiter.sv =====
// self-checking testbench for reader_writer_lock_arbiter: lock events in, one result per event
// depends on rwla_pkg and the arbiter rtl; predicts untyped results from its own copy of lock state
`timescale 1ns / 1ps

module tb_reader_writer_lock_arbiter
    import rwla_pkg::*;
();

    localparam int          REQ_COUNT     = 8;
    localparam int          PHASES        = 6;
    localparam int          PHASE_ITEMS   = 155;
    localparam int          SETTLE_CYCLES = 24;
    localparam int unsigned QUIET_LIMIT   = 2000;

    typedef struct packed {
        in_item_t  ev;
        logic      typed;
        out_item_t want;
    } plan_row_t;

    localparam plan_row_t LOCK_PLAN [24] = '{
        '{'{3'd0, MODE_WR_REL}, 1'b1, '{8'h00, 1'b0, 1'b0, 4'd0, 4'd0, 4'd0, 1'b1}},
        '{'{3'd7, MODE_RD_REL}, 1'b1, '{8'h00, 1'b0, 1'b0, 4'd0, 4'd0, 4'd0, 1'b1}},
        '{'{3'd0, MODE_RD_REQ}, 1'b1, '{8'h01, 1'b0, 1'b0, 4'd1, 4'd0, 4'd0, 1'b0}},
        '{'{3'd0, MODE_RD_REQ}, 1'b1, '{8'h00, 1'b0, 1'b0, 4'd1, 4'd0, 4'd0, 1'b1}},
        '{'{3'd7, MODE_WR_REQ}, 1'b0, '0},
        '{'{3'd1, MODE_RD_REQ}, 1'b0, '0},
        '{'{3'd2, MODE_RD_REQ}, 1'b0, '0},
        '{'{3'd3, MODE_RD_REQ}, 1'b0, '0},
        '{'{3'd4, MODE_RD_REQ}, 1'b0, '0},
        '{'{3'd6, MODE_WR_REQ}, 1'b0, '0},
        '{'{3'd0, MODE_RD_REL}, 1'b0, '0},
        '{'{3'd1, MODE_RD_REL}, 1'b0, '0},
        '{'{3'd2, MODE_RD_REL}, 1'b0, '0},
        '{'{3'd3, MODE_RD_REL}, 1'b0, '0},
        '{'{3'd5, MODE_RD_REQ}, 1'b0, '0},
        '{'{3'd6, MODE_WR_REL}, 1'b0, '0},
        '{'{3'd7, MODE_WR_REL}, 1'b0, '0},
        '{'{3'd4, MODE_RD_REL}, 1'b0, '0},
        '{'{3'd5, MODE_RD_REL}, 1'b0, '0},
        '{'{3'd7, MODE_WR_REQ}, 1'b0, '0},
        '{'{3'd7, MODE_RD_REQ}, 1'b0, '0},
        '{'{3'd7, MODE_WR_REL}, 1'b0, '0},
        '{'{3'd0, MODE_WR_REQ}, 1'b0, '0},
        '{'{3'd0, MODE_WR_REL}, 1'b0, '0}
    };

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    in_item_t   s_item    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    out_item_t  m_item;
    logic       cfg_we    = 1'b0;
    logic [3:0] cfg_wdata = 4'd0;

    // predicted lock state
    logic [7:0] rd_wait;
    logic [7:0] wr_wait;
    logic [7:0] rd_hold;
    logic       wr_busy;
    logic [2:0] wr_owner;
    logic [3:0] bypass_count;
    logic       favor_wr;
    logic [3:0] limit_now;

    out_item_t   results_due [$];
    out_item_t   due_item;
    logic        calm         = 1'b0;
    int          failures     = 0;
    int          events_sent  = 0;
    int          results_seen = 0;
    int          writer_grants = 0;
    int          priority_hits = 0;
    int unsigned quiet_cycles = 0;

    reader_writer_lock_arbiter #(
        .REQUESTERS(REQ_COUNT)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic readers_held_off();
        return wr_busy || (favor_wr && wr_wait != 8'd0);
    endfunction

    function automatic void seat_reader(int unsigned r);
        if (wr_wait != 8'd0 && !favor_wr) begin
            if (bypass_count != DELAY_MAX) bypass_count = bypass_count + 4'd1;
            if (bypass_count >= limit_now) favor_wr = 1'b1;
        end
        rd_hold[r] = 1'b1;
    endfunction

    function automatic int unsigned lowest_set(logic [7:0] m);
        int unsigned i;
        for (i = 0; i < 7; i++) begin
            if (m[i]) return i;
        end
        return 7;
    endfunction

    function automatic logic [7:0] seat_writer(int unsigned w);
        wr_wait[w]   = 1'b0;
        wr_busy      = 1'b1;
        wr_owner     = 3'(w);
        bypass_count = 4'd0;
        favor_wr     = 1'b0;
        return 8'd1 << w;
    endfunction

    function automatic out_item_t apply_lock_event(in_item_t ev);
        out_item_t   res;
        logic [7:0]  bit_r;
        logic        owns_wr;
        logic        involved;
        int unsigned i;
        res      = '0;
        bit_r    = 8'd1 << ev.requester;
        owns_wr  = wr_busy && wr_owner == ev.requester;
        involved = ((rd_wait | wr_wait | rd_hold) & bit_r) != 8'd0 || owns_wr;
        case (ev.mode)
            MODE_RD_REQ: begin
                if (involved) begin
                    res.bad_event = 1'b1;
                end else if (readers_held_off()) begin
                    rd_wait = rd_wait | bit_r;
                end else begin
                    seat_reader(ev.requester);
                    res.grant_mask = bit_r;
                end
            end
            MODE_RD_REL: begin
                if ((rd_hold & bit_r) == 8'd0) begin
                    res.bad_event = 1'b1;
                end else begin
                    rd_hold = rd_hold & ~bit_r;
                    if (rd_hold == 8'd0 && wr_wait != 8'd0 && !wr_busy) begin
                        res.grant_mask     = seat_writer(lowest_set(wr_wait));
                        res.grant_is_write = 1'b1;
                    end
                end
            end
            MODE_WR_REQ: begin
                if (involved) begin
                    res.bad_event = 1'b1;
                end else if (!wr_busy && rd_hold == 8'd0) begin
                    res.grant_mask     = seat_writer(ev.requester);
                    res.grant_is_write = 1'b1;
                end else begin
                    wr_wait = wr_wait | bit_r;
                end
            end
            default: begin
                if (!owns_wr) begin
                    res.bad_event = 1'b1;
                end else begin
                    wr_busy = 1'b0;
                    if (wr_wait != 8'd0 && favor_wr) begin
                        res.grant_mask     = seat_writer(lowest_set(wr_wait));
                        res.grant_is_write = 1'b1;
                    end else if (rd_wait != 8'd0) begin
                        // woken readers re-check in index order
                        for (i = 0; i < REQ_COUNT; i++) begin
                            if (rd_wait[i] && !readers_held_off()) begin
                                rd_wait[i] = 1'b0;
                                seat_reader(i);
                                res.grant_mask[i] = 1'b1;
                            end
                        end
                    end else if (wr_wait != 8'd0) begin
                        res.grant_mask     = seat_writer(lowest_set(wr_wait));
                        res.grant_is_write = 1'b1;
                    end
                end
            end
        endcase
        res.priority_flag   = favor_wr;
        res.reader_count    = 4'($countones(rd_hold));
        res.readers_waiting = 4'($countones(rd_wait));
        res.writers_waiting = 4'($countones(wr_wait));
        return res;
    endfunction

    // mostly events that fit the current lock state, some noise
    function automatic in_item_t pick_lock_event();
        in_item_t    ev;
        int unsigned r;
        int unsigned k;
        int unsigned idx;
        r           = $urandom_range(0, REQ_COUNT - 1);
        ev.requester = 3'(r);
        ev.mode      = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 99) < 15) return ev;
        for (k = 0; k < REQ_COUNT; k++) begin
            idx = (r + k) % REQ_COUNT;
            if (!rd_wait[idx] && !wr_wait[idx]) begin
                ev.requester = 3'(idx);
                if (rd_hold[idx]) begin
                    ev.mode = MODE_RD_REL;
                end else if (wr_busy && wr_owner == 3'(idx)) begin
                    ev.mode = MODE_WR_REL;
                end else if ($urandom_range(0, 99) < 65) begin
                    ev.mode = MODE_RD_REQ;
                end else begin
                    ev.mode = MODE_WR_REQ;
                end
                return ev;
            end
        end
        return ev;
    endfunction

    // called at a falling edge, returns at the falling edge after the accept
    task automatic push_event(input in_item_t ev, input logic typed, input out_item_t want);
        out_item_t guess;
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= ev;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        guess = apply_lock_event(ev);
        results_due.push_back(typed ? want : guess);
        events_sent++;
        @(negedge aclk);
    endtask

    task automatic set_delay_limit(input logic [3:0] value);
        s_valid <= 1'b0;
        while (results_due.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        limit_now = value;
    endtask

    always begin
        @(negedge aclk);
        if (!calm && $urandom_range(0, 5) == 0) begin
            m_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
        m_ready <= 1'b1;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (results_due.size() == 0) begin
                $error("result with no event outstanding: %h", m_item);
                failures++;
            end else begin
                due_item = results_due.pop_front();
                if (m_item.grant_is_write) writer_grants++;
                if (m_item.priority_flag) priority_hits++;
                if (m_item.grant_mask !== due_item.grant_mask) begin
                    $error("grant_mask expected %h got %h",
                           due_item.grant_mask, m_item.grant_mask);
                    failures++;
                end
                if (m_item.grant_is_write !== due_item.grant_is_write) begin
                    $error("grant_is_write expected %b got %b",
                           due_item.grant_is_write, m_item.grant_is_write);
                    failures++;
                end
                if (m_item.priority_flag !== due_item.priority_flag) begin
                    $error("priority_flag expected %b got %b",
                           due_item.priority_flag, m_item.priority_flag);
                    failures++;
                end
                if (m_item.reader_count !== due_item.reader_count) begin
                    $error("reader_count expected %0d got %0d",
                           due_item.reader_count, m_item.reader_count);
                    failures++;
                end
                if (m_item.readers_waiting !== due_item.readers_waiting) begin
                    $error("readers_waiting expected %0d got %0d",
                           due_item.readers_waiting, m_item.readers_waiting);
                    failures++;
                end
                if (m_item.writers_waiting !== due_item.writers_waiting) begin
                    $error("writers_waiting expected %0d got %0d",
                           due_item.writers_waiting, m_item.writers_waiting);
                    failures++;
                end
                if (m_item.bad_event !== due_item.bad_event) begin
                    $error("bad_event expected %b got %b",
                           due_item.bad_event, m_item.bad_event);
                    failures++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("no handshake for %0d cycles, %0d results outstanding",
                     quiet_cycles, results_due.size());
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int          n;
        int          p;
        int          j;
        logic [3:0]  lim;
        rd_wait      = '0;
        wr_wait      = '0;
        rd_hold      = '0;
        wr_busy      = 1'b0;
        wr_owner     = '0;
        bypass_count = '0;
        favor_wr     = 1'b0;
        limit_now    = LIMIT_RESET;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (n = 0; n < $size(LOCK_PLAN); n++) begin
            push_event(LOCK_PLAN[n].ev, LOCK_PLAN[n].typed, LOCK_PLAN[n].want);
        end

        // limit settings: lowest, highest, random, last phase with no idling
        for (p = 0; p < PHASES; p++) begin
            if (p == 0) lim = 4'd1;
            else if (p == 1) lim = 4'd15;
            else lim = 4'($urandom_range(1, 15));
            set_delay_limit(lim);
            if (p == PHASES - 1) calm = 1'b1;
            for (j = 0; j < PHASE_ITEMS; j++) begin
                push_event(pick_lock_event(), 1'b0, '0);
            end
        end

        s_valid <= 1'b0;
        while (results_due.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);

        $display("%0d lock events over %0d delay limit settings, %0d results checked",
                 events_sent, PHASES + 1, results_seen);
        $display("%0d writer grants, %0d results with writer priority on",
                 writer_grants, priority_hits);
        if (failures == 0 && results_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rwla_pkg.sv
rtl/rwla_ctrl.sv
rtl/rwla_datapath.sv
rtl/reader_writer_lock_arbiter.sv
rtl/rwla_checker.sv
tb/tb_reader_writer_lock_arbiter.sv
